// ===== design/cpr_pkg.sv =====
// Shared constants, register indexes and controller states for the clock
// page replacement block. No dependencies.
`default_nettype none

package cpr_pkg;

  localparam int DEF_VIRTUAL_PAGES = 1024;
  localparam int DEF_MAX_FRAMES    = 64;

  localparam int ADDR_W      = 32;
  localparam int FRAME_W     = 6;
  localparam int EPAGE_W     = 10;
  localparam int COUNT_W     = 32;
  localparam int FCOUNT_W    = 7;
  localparam int SHIFT_W     = 5;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_INDEX_W = 1;

  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 7'd64;
  localparam logic [SHIFT_W-1:0]  PAGE_SHIFT_RST  = 5'd12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_COUNT = 1'b0,
    REG_PAGE_SHIFT  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_VREAD,
    ST_VCHECK,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== design/cpr_page_table.sv =====
// Per-page table memory holding present, dirty and frame for each virtual page.
// Runs a clearing pass after reset. Depends on cpr_pkg.
`default_nettype none

module cpr_page_table #(
  parameter int VIRTUAL_PAGES = cpr_pkg::DEF_VIRTUAL_PAGES,
  parameter int ENTRY_W       = 8,
  localparam int PAGE_W       = $clog2(VIRTUAL_PAGES)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [PAGE_W-1:0]  rd_addr,
  output logic      [ENTRY_W-1:0] rd_data,
  input  wire logic               wr_en,
  input  wire logic [PAGE_W-1:0]  wr_addr,
  input  wire logic [ENTRY_W-1:0] wr_data,
  output logic                    clearing
);
  import cpr_pkg::*;

  logic [ENTRY_W-1:0] mem [VIRTUAL_PAGES];
  logic [PAGE_W-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == PAGE_W'(VIRTUAL_PAGES - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/clock_page_replacement.sv =====
// Top level of the clock (second chance) page replacement block: controller,
// frame memory and reference bits. Depends on cpr_pkg and cpr_page_table.
//
//   channel   handshake           payload
//   access    start / busy        address, is_write
//   result    done (one cycle)    hit, frame, evicted_valid, evicted_page, writeback,
//                                 range_error, hits_total, misses_total, writebacks_total
//   config    cfg_write           cfg_index, cfg_data
//
// The sweep tests one reference bit per cycle; table reads go through the
// registered-read page table and frame memories.
// After reset the page table is cleared one entry per cycle, with busy held
// high until the cycle after the pass ends.
// The receiver cannot stall a result.
`default_nettype none

module clock_page_replacement #(
  parameter int VIRTUAL_PAGES = cpr_pkg::DEF_VIRTUAL_PAGES,
  parameter int MAX_FRAMES    = cpr_pkg::DEF_MAX_FRAMES
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [cpr_pkg::ADDR_W-1:0]     address,
  input  wire logic                           is_write,
  input  wire logic                           cfg_write,
  input  wire logic [cpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cpr_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                done,
  output logic                                hit,
  output logic      [cpr_pkg::FRAME_W-1:0]    frame,
  output logic                                evicted_valid,
  output logic      [cpr_pkg::EPAGE_W-1:0]    evicted_page,
  output logic                                writeback,
  output logic                                range_error,
  output logic      [cpr_pkg::COUNT_W-1:0]    hits_total,
  output logic      [cpr_pkg::COUNT_W-1:0]    misses_total,
  output logic      [cpr_pkg::COUNT_W-1:0]    writebacks_total
);
  import cpr_pkg::*;

  localparam int PAGE_W  = $clog2(VIRTUAL_PAGES);
  localparam int FIDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NUM_W   = $clog2(MAX_FRAMES + 1);
  localparam int CMP_W   = (NUM_W > FCOUNT_W) ? NUM_W : FCOUNT_W;
  localparam int ENTRY_W = FIDX_W + 2;

  state_t state, state_next;

  logic [FCOUNT_W-1:0]   frame_count;
  logic [SHIFT_W-1:0]    page_shift;
  logic [NUM_W-1:0]      n_use;
  logic [ADDR_W-1:0]     page_full;
  logic                  in_range;

  logic [PAGE_W-1:0]     page;
  logic                  wr_acc;
  logic [FIDX_W-1:0]     frame_sel;
  logic [FIDX_W-1:0]     idx;
  logic [FIDX_W-1:0]     idx_wrap;
  logic [FIDX_W-1:0]     hand;
  logic [NUM_W-1:0]      filled;
  logic [PAGE_W-1:0]     victim;
  logic [MAX_FRAMES-1:0] ref_bits;
  logic [COUNT_W-1:0]    hit_cnt;
  logic [COUNT_W-1:0]    miss_cnt;
  logic [COUNT_W-1:0]    wb_cnt;

  logic [PAGE_W-1:0]     fmem [MAX_FRAMES];
  logic [PAGE_W-1:0]     fm_rd_data;
  logic [FIDX_W-1:0]     fm_rd_addr;
  logic                  fm_wr_en;

  logic [PAGE_W-1:0]     pt_rd_addr;
  logic [ENTRY_W-1:0]    pt_rd_data;
  logic                  pt_wr_en;
  logic [PAGE_W-1:0]     pt_wr_addr;
  logic [ENTRY_W-1:0]    pt_wr_data;
  logic                  pt_clearing;
  logic                  pt_present;
  logic                  pt_dirty;
  logic [FIDX_W-1:0]     pt_frame;

  cpr_page_table #(
    .VIRTUAL_PAGES(VIRTUAL_PAGES),
    .ENTRY_W      (ENTRY_W)
  ) u_page_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (pt_rd_addr),
    .rd_data (pt_rd_data),
    .wr_en   (pt_wr_en),
    .wr_addr (pt_wr_addr),
    .wr_data (pt_wr_data),
    .clearing(pt_clearing)
  );

  assign pt_present = pt_rd_data[ENTRY_W-1];
  assign pt_dirty   = pt_rd_data[ENTRY_W-2];
  assign pt_frame   = pt_rd_data[FIDX_W-1:0];

  assign page_full = address >> page_shift;
  assign in_range  = page_full < ADDR_W'(VIRTUAL_PAGES);

  always_comb begin
    logic [CMP_W-1:0] fc_ext;
    fc_ext = CMP_W'(frame_count);
    if (fc_ext == '0) begin
      n_use = NUM_W'(1);
    end else if (fc_ext > CMP_W'(MAX_FRAMES)) begin
      n_use = NUM_W'(MAX_FRAMES);
    end else begin
      n_use = NUM_W'(frame_count);
    end
  end

  always_comb begin
    if ((NUM_W'(idx) + NUM_W'(1)) == n_use) begin
      idx_wrap = '0;
    end else begin
      idx_wrap = idx + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (!pt_clearing) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) state_next = in_range ? ST_LOOKUP : ST_DONE;
      end
      ST_LOOKUP: begin
        if (pt_present) state_next = ST_DONE;
        else if (filled < n_use) state_next = ST_FILL;
        else state_next = ST_SWEEP;
      end
      ST_SWEEP:  if (!ref_bits[idx]) state_next = ST_VREAD;
      ST_VREAD:  state_next = ST_VCHECK;
      ST_VCHECK: state_next = ST_FILL;
      ST_FILL:   state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_DONE);
    pt_rd_addr = page_full[PAGE_W-1:0];
    pt_wr_en   = 1'b0;
    pt_wr_addr = page;
    pt_wr_data = '0;
    fm_rd_addr = idx;
    fm_wr_en   = 1'b0;
    case (state)
      ST_LOOKUP: begin
        pt_wr_en   = pt_present && wr_acc;
        pt_wr_data = {1'b1, 1'b1, pt_frame};
      end
      ST_VREAD: begin
        pt_rd_addr = fm_rd_data;
      end
      ST_VCHECK: begin
        pt_wr_en   = 1'b1;
        pt_wr_addr = victim;
        pt_wr_data = '0;
      end
      ST_FILL: begin
        pt_wr_en   = 1'b1;
        pt_wr_data = {1'b1, wr_acc, frame_sel};
        fm_wr_en   = 1'b1;
      end
      default: begin
        pt_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_wr_en) begin
      fmem[frame_sel] <= page;
    end
    fm_rd_data <= fmem[fm_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RST;
      page_shift  <= PAGE_SHIFT_RST;
      ref_bits    <= '0;
      filled      <= '0;
      hand        <= '0;
      hit_cnt     <= '0;
      miss_cnt    <= '0;
      wb_cnt      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_COUNT: frame_count <= cfg_data[FCOUNT_W-1:0];
          REG_PAGE_SHIFT:  page_shift  <= cfg_data[SHIFT_W-1:0];
          default:         page_shift  <= page_shift;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            page          <= page_full[PAGE_W-1:0];
            wr_acc        <= is_write;
            hit           <= 1'b0;
            frame         <= '0;
            evicted_valid <= 1'b0;
            evicted_page  <= '0;
            writeback     <= 1'b0;
            range_error   <= !in_range;
          end
        end
        ST_LOOKUP: begin
          if (pt_present) begin
            hit                <= 1'b1;
            frame              <= FRAME_W'(pt_frame);
            ref_bits[pt_frame] <= 1'b1;
            if (hit_cnt != '1) hit_cnt <= hit_cnt + 1'b1;
          end else begin
            if (miss_cnt != '1) miss_cnt <= miss_cnt + 1'b1;
            if (filled < n_use) begin
              frame_sel <= FIDX_W'(filled);
              filled    <= filled + 1'b1;
            end else begin
              idx <= (NUM_W'(hand) < n_use) ? hand : '0;
            end
          end
        end
        ST_SWEEP: begin
          if (ref_bits[idx]) begin
            ref_bits[idx] <= 1'b0;
            idx           <= idx_wrap;
          end else begin
            frame_sel <= idx;
            hand      <= idx_wrap;
          end
        end
        ST_VREAD: begin
          victim <= fm_rd_data;
        end
        ST_VCHECK: begin
          evicted_valid <= 1'b1;
          evicted_page  <= EPAGE_W'(victim);
          if (pt_dirty) begin
            writeback <= 1'b1;
            if (wb_cnt != '1) wb_cnt <= wb_cnt + 1'b1;
          end
        end
        ST_FILL: begin
          ref_bits[frame_sel] <= 1'b0;
          frame               <= FRAME_W'(frame_sel);
        end
        default: begin
          hand <= hand;
        end
      endcase
    end
  end

  assign hits_total       = hit_cnt;
  assign misses_total     = miss_cnt;
  assign writebacks_total = wb_cnt;

  a_hit_reported: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP && pt_present) |=> (done && hit))
    else $error("resident page not reported as a hit");

  a_wb_needs_evict: assert property (@(posedge clk) disable iff (rst)
    (done && writeback) |-> evicted_valid)
    else $error("writeback without an eviction");

  a_range_quiet: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (!hit && !evicted_valid && !writeback))
    else $error("out of range access changed the result");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    pt_clearing |-> busy)
    else $error("accepting accesses while the page table is clearing");

  a_hand_in_use: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && !ref_bits[idx]) |=> (NUM_W'(hand) < n_use))
    else $error("clock hand left the frames in use");

endmodule

`default_nettype wire

// ===== dv/cpr_access_checker.sv =====
// Checker for the clock page replacement block: watches the access, config and
// result channels, predicts each result beat and compares it field by field.
// Depends on cpr_pkg.
module cpr_access_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [cpr_pkg::ADDR_W-1:0]   address,
  input  logic                         is_write,
  input  logic                         cfg_write,
  input  logic [cpr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cpr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                         done,
  input  logic                         hit,
  input  logic [cpr_pkg::FRAME_W-1:0]  frame,
  input  logic                         evicted_valid,
  input  logic [cpr_pkg::EPAGE_W-1:0]  evicted_page,
  input  logic                         writeback,
  input  logic                         range_error,
  input  logic [cpr_pkg::COUNT_W-1:0]  hits_total,
  input  logic [cpr_pkg::COUNT_W-1:0]  misses_total,
  input  logic [cpr_pkg::COUNT_W-1:0]  writebacks_total,
  output int                           failures,
  output int                           pending
);
  import cpr_pkg::*;

  localparam int PAGES  = DEF_VIRTUAL_PAGES;
  localparam int FRAMES = DEF_MAX_FRAMES;

  typedef struct {
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic                 ev_valid;
    logic [EPAGE_W-1:0]   ev_page;
    logic                 wb;
    logic                 rerr;
    logic [COUNT_W-1:0]   hits;
    logic [COUNT_W-1:0]   misses;
    logic [COUNT_W-1:0]   wbs;
  } outcome_t;

  logic [FCOUNT_W-1:0] frame_count;
  logic [SHIFT_W-1:0]  page_shift;
  logic                resident [PAGES];
  logic                dirty [PAGES];
  logic [FRAME_W-1:0]  page_frame [PAGES];
  logic [EPAGE_W-1:0]  frame_page [FRAMES];
  logic                ref_bit [FRAMES];
  int                  frames_filled;
  int                  clock_hand;
  logic [COUNT_W-1:0]  hit_count;
  logic [COUNT_W-1:0]  miss_count;
  logic [COUNT_W-1:0]  wb_count;

  outcome_t expected_outcomes [$];
  int       mismatches = 0;

  assign failures = mismatches;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic outcome_t predict_access(logic [ADDR_W-1:0] addr, logic wr);
    logic [ADDR_W-1:0]  vpage;
    logic [EPAGE_W-1:0] pg;
    logic [EPAGE_W-1:0] victim;
    int                 n;
    int                 hand;
    int                 choice;
    int                 idx;
    bit                 found;
    outcome_t           r;
    r = '{default: '0};
    vpage = addr >> page_shift;
    pg = vpage[EPAGE_W-1:0];
    if (vpage >= PAGES) begin
      r.rerr = 1'b1;
    end else if (resident[pg]) begin
      r.hit = 1'b1;
      hit_count = sat_inc(hit_count);
      r.frame = page_frame[pg];
      ref_bit[r.frame] = 1'b1;
      if (wr) dirty[pg] = 1'b1;
    end else begin
      n = (frame_count == 0) ? 1 : (frame_count > FRAMES) ? FRAMES : int'(frame_count);
      miss_count = sat_inc(miss_count);
      if (frames_filled < n) begin
        r.frame = frames_filled[FRAME_W-1:0];
        frames_filled++;
      end else begin
        hand = (clock_hand < n) ? clock_hand : 0;
        choice = hand;
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          idx = (hand + i) % n;
          if (!found) begin
            if (ref_bit[idx]) begin
              ref_bit[idx] = 1'b0;
            end else begin
              choice = idx;
              found = 1'b1;
            end
          end
        end
        clock_hand = (choice + 1) % n;
        r.frame = choice[FRAME_W-1:0];
        victim = frame_page[choice];
        r.ev_valid = 1'b1;
        r.ev_page = victim;
        if (dirty[victim]) begin
          r.wb = 1'b1;
          wb_count = sat_inc(wb_count);
        end
        resident[victim] = 1'b0;
        dirty[victim] = 1'b0;
      end
      resident[pg] = 1'b1;
      dirty[pg] = wr;
      page_frame[pg] = r.frame;
      frame_page[r.frame] = pg;
      ref_bit[r.frame] = 1'b0;
    end
    r.hits = hit_count;
    r.misses = miss_count;
    r.wbs = wb_count;
    return r;
  endfunction

  task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      frame_count = FRAME_COUNT_RST;
      page_shift = PAGE_SHIFT_RST;
      for (int p = 0; p < PAGES; p++) begin
        resident[p] = 1'b0;
        dirty[p] = 1'b0;
      end
      for (int f = 0; f < FRAMES; f++) ref_bit[f] = 1'b0;
      frames_filled = 0;
      clock_hand = 0;
      hit_count = '0;
      miss_count = '0;
      wb_count = '0;
      expected_outcomes.delete();
      pending <= 0;
    end else begin
      if (done) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result beat with no access outstanding", $time);
          mismatches++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("hit", COUNT_W'(want.hit), COUNT_W'(hit));
          check_field("frame", COUNT_W'(want.frame), COUNT_W'(frame));
          check_field("evicted_valid", COUNT_W'(want.ev_valid), COUNT_W'(evicted_valid));
          check_field("evicted_page", COUNT_W'(want.ev_page), COUNT_W'(evicted_page));
          check_field("writeback", COUNT_W'(want.wb), COUNT_W'(writeback));
          check_field("range_error", COUNT_W'(want.rerr), COUNT_W'(range_error));
          check_field("hits_total", want.hits, hits_total);
          check_field("misses_total", want.misses, misses_total);
          check_field("writebacks_total", want.wbs, writebacks_total);
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_FRAME_COUNT) frame_count = cfg_data[FCOUNT_W-1:0];
        else if (cfg_index == REG_PAGE_SHIFT) page_shift = cfg_data[SHIFT_W-1:0];
      end
      if (start && !busy) expected_outcomes.push_back(predict_access(address, is_write));
      pending <= expected_outcomes.size();
    end
  end

endmodule

// ===== dv/tb_clock_page_replacement.sv =====
// Top of the clock page replacement testbench: clock, reset, access and
// config stimulus, and the final verdict. Depends on cpr_pkg, the block and
// cpr_access_checker.
module tb_clock_page_replacement;
  import cpr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [ADDR_W-1:0]      address = '0;
  logic                   is_write = 1'b0;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   busy;
  logic                   done;
  logic                   hit;
  logic [FRAME_W-1:0]     frame;
  logic                   evicted_valid;
  logic [EPAGE_W-1:0]     evicted_page;
  logic                   writeback;
  logic                   range_error;
  logic [COUNT_W-1:0]     hits_total;
  logic [COUNT_W-1:0]     misses_total;
  logic [COUNT_W-1:0]     writebacks_total;
  int                     failures;
  int                     pending;

  clock_page_replacement dut (.*);

  cpr_access_checker access_monitor (.*);

  initial forever #5 clk = ~clk;

  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] addr_of(int unsigned page, int shift);
    logic [ADDR_W-1:0] low;
    low = $urandom;
    low = (shift == 0) ? '0 : low & ((32'h1 << shift) - 1);
    return (32'(page) << shift) | low;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic issue(logic [ADDR_W-1:0] a, logic wr, int gap);
    start <= 1'b1;
    address <= a;
    is_write <= wr;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      address <= $urandom;
      is_write <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int                ph;
    int                n;
    int                ws;
    int                base;
    int                r;
    int                gap;
    int                shift;
    logic [FCOUNT_W-1:0] fc;
    bit                quiet;
    logic [ADDR_W-1:0] a;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed beats at the reset settings, then the frame count and shift extremes.
    issue(32'h0000_0000, 1'b0, 0);
    issue(32'h0000_0000, 1'b1, 1);
    issue(32'hFFFF_FFFF, 1'b0, 0);
    issue(32'h003F_FFFF, 1'b1, 2);
    issue(32'h0040_0000, 1'b0, 0);
    settle();
    write_reg(REG_FRAME_COUNT, 7'd2);
    issue(addr_of(5, 12), 1'b1, 0);
    issue(addr_of(5, 12), 1'b0, 1);
    issue(addr_of(0, 12), 1'b0, 0);
    issue(addr_of(7, 12), 1'b0, 0);
    settle();
    write_reg(REG_FRAME_COUNT, 7'd0);
    issue(addr_of(9, 12), 1'b1, 0);
    issue(addr_of(5, 12), 1'b0, 0);
    issue(addr_of(7, 12), 1'b0, 1);
    settle();
    write_reg(REG_FRAME_COUNT, 7'd127);
    issue(addr_of(11, 12), 1'b0, 0);
    settle();
    write_reg(REG_PAGE_SHIFT, 7'd0);
    issue(32'd1023, 1'b1, 0);
    issue(32'd1024, 1'b0, 0);
    issue(32'd0, 1'b0, 3);
    settle();
    write_reg(REG_PAGE_SHIFT, 7'h7F);
    issue(32'h8000_0000, 1'b1, 0);
    issue(32'h7FFF_FFFF, 1'b0, 0);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: fc = 7'd1;
        1: fc = 7'd64;
        2: fc = 7'd127;
        3: fc = 7'd0;
        default: begin
          case ($urandom_range(0, 3))
            0: fc = 7'($urandom_range(1, 8));
            1: fc = 7'($urandom_range(65, 127));
            default: fc = 7'($urandom_range(1, 64));
          endcase
        end
      endcase
      case (ph)
        0: shift = 0;
        1: shift = 31;
        2: shift = 12;
        3: shift = 22;
        default: shift = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(8, 14);
      endcase
      n = (fc == 0) ? 1 : (fc > 64) ? 64 : int'(fc);
      ws = n + $urandom_range(0, n + 2);
      base = $urandom_range(0, 1024 - ws);
      quiet = ($urandom_range(0, 3) == 0);
      write_reg(REG_FRAME_COUNT, fc);
      write_reg(REG_PAGE_SHIFT, {2'($urandom_range(0, 3)), 5'(shift)});
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 75) a = addr_of(base + $urandom_range(0, ws - 1), shift);
        else if (r < 88) a = addr_of($urandom_range(0, 1023), shift);
        else a = $urandom;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        issue(a, 1'($urandom_range(0, 1)), gap);
      end
      settle();
    end

    @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== clock_page_replacement.f =====
design/cpr_pkg.sv
design/cpr_page_table.sv
design/clock_page_replacement.sv
dv/cpr_access_checker.sv
dv/tb_clock_page_replacement.sv
